// ----- hw/rtl/ssg_pkg.sv -----
// Shared types and constants for the Sobol sample generator.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package ssg_pkg;

    // Fixed widths of the transaction fields.
    localparam int unsigned OP_W       = 1;
    localparam int unsigned DIM_W      = 6;
    localparam int unsigned COL_W      = 6;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned IDX_W      = 52;

    // Operation codes carried in the op field.
    localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/ssg_ifs.sv -----
// Valid/ready channel interfaces of the Sobol sample generator.
// Depends on ssg_pkg for the field widths.
`default_nettype none

interface ssg_in_if;
    import ssg_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DIM_W-1:0]  dim;
    logic [COL_W-1:0]  column;
    logic [WORD_W-1:0] column_value;
    logic [IDX_W-1:0]  sample_index;

    modport source (output valid, op, dim, column, column_value, sample_index,
                    input ready);
    modport sink   (input valid, op, dim, column, column_value, sample_index,
                    output ready);
endinterface

interface ssg_out_if;
    import ssg_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] sample_fraction;

    modport source (output valid, sample_fraction, input ready);
    modport sink   (input valid, sample_fraction, output ready);
endinterface

interface ssg_cfg_if;
    import ssg_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sobol_sample_generator_unit.sv -----
// Top level of the Sobol sample generator: column store, sequencer and XOR unit.
// Depends on ssg_pkg and on the channel interfaces in ssg_ifs.sv.
`default_nettype none

// Usage
// The input channel carries two kinds of transaction. A load (op = OP_LOAD)
// writes one 32-bit generator column of one dimension into the column store
// and gives no result; loads outside NUM_DIMS or COLUMNS are dropped. A
// sample (op = OP_SAMPLE) starts from the scramble register and XORs in the
// column of every set bit of index[NB-1:0], giving one 32-bit output fraction.
// The configuration channel writes the scramble register; it is always ready
// and must only be used while the block is idle.
// A load is absorbed in the cycle it is accepted. A sample walks
// min(COLUMNS, 52) columns through the single read port of the column store,
// one column per cycle, through a registered read; the result then enters the
// output register, and the input is ready again in that same cycle, so a new
// sample is not accepted before the previous result has reached the register.
// Reset clears the sequencer, the output valid flag and the scramble register;
// the column store is not cleared and must be loaded before it is sampled.
// If the receiver stalls, the result waits in the output register while the
// block accepts and computes the next item, which then waits for the register.

module sobol_sample_generator_unit #(
    parameter int NUM_DIMS = 64,
    parameter int COLUMNS  = 52
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssg_in_if.sink     i_in,
    ssg_out_if.source  o_out,
    ssg_cfg_if.sink    i_cfg
);
    import ssg_pkg::*;

    // Number of index bits that can select a column.
    localparam int NB    = (COLUMNS < IDX_W) ? COLUMNS : IDX_W;
    localparam int DEPTH = NUM_DIMS * COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(NB + 1);

    // Column store, one word per dimension and column.
    logic [WORD_W-1:0] mem [DEPTH];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_addr, n_addr;
    logic [NB-1:0]     r_idx, n_idx;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic              r_rvalid, n_rvalid;
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_scramble;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;

    logic              w_in_ready;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic              w_rd_en;
    logic              w_slot_free;
    logic              w_dim_ok;
    logic              w_col_ok;
    logic [AW-1:0]     w_base;

    assign w_dim_ok    = (32'(i_in.dim) < 32'(NUM_DIMS));
    assign w_col_ok    = (32'(i_in.column) < 32'(COLUMNS));
    assign w_base      = AW'(32'(i_in.dim) * 32'(COLUMNS));
    assign w_wr_addr   = AW'(32'(i_in.dim) * 32'(COLUMNS) + 32'(i_in.column));
    assign w_slot_free = !r_out_valid || o_out.ready;

    // Sequencer: next state, datapath updates and handshakes.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_rvalid    = 1'b0;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_in_ready  = 1'b0;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;

        // The held result leaves when the receiver takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.op == OP_SAMPLE) begin
                        // A missing dimension selects nothing: the index is
                        // zeroed so that only the scramble value remains.
                        n_idx   = w_dim_ok ? i_in.sample_index[NB-1:0] : '0;
                        n_addr  = w_dim_ok ? w_base : '0;
                        n_acc   = r_scramble;
                        n_cnt   = '0;
                        n_state = ST_RUN;
                    end else begin
                        w_wr_en = w_dim_ok && w_col_ok;
                    end
                end
            end
            ST_RUN: begin
                w_rd_en  = (r_cnt < CW'(NB));
                n_rvalid = w_rd_en;
                if (w_rd_en) begin
                    n_addr = r_addr + 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
                // Column read in the previous cycle lines up with index bit 0.
                if (r_rvalid) begin
                    if (r_idx[0]) begin
                        n_acc = r_acc ^ r_rdata;
                    end
                    n_idx = r_idx >> 1;
                end
                if (!w_rd_en) begin
                    if (w_slot_free) begin
                        n_out_data  = n_acc;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (w_slot_free) begin
                    n_out_data  = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_scramble  <= '0;
        end else begin
            r_state     <= n_state;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_scramble <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    // Column store: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_in.column_value;
        end
        if (w_rd_en) begin
            r_rdata <= mem[r_addr];
        end
    end

    assign i_in.ready            = w_in_ready;
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.sample_fraction = r_out_data;

`ifndef SYNTHESIS
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.op == OP_SAMPLE)
        |=> (r_state == ST_RUN && r_cnt == '0))
        else $error("sample transaction did not start the column walk");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_cnt <= CW'(NB)))
        else $error("column counter ran past the last column");

    a_rdata_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvalid |-> (r_state == ST_RUN))
        else $error("column read data arrived outside the walk");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> r_out_valid)
        else $error("result held back although the output register was free");
`endif

endmodule

`default_nettype wire
